/* rtl/fixed_partition_fit_allocator_defines.svh */
// Assertion macros of the fixed partition fit allocator modules.
// No dependencies; included by files that carry concurrent checks.
`ifndef FIXED_PARTITION_FIT_ALLOCATOR_DEFINES_SVH
`define FIXED_PARTITION_FIT_ALLOCATOR_DEFINES_SVH

// same-cycle implication, disabled in reset
`define FPFA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fpfa check failed");

// next-cycle implication, disabled in reset
`define FPFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fpfa check failed");

`endif

/* rtl/fpfa_pkg.sv */
// Shared types, codes and widths of the fixed partition fit allocator.
// No dependencies.
`timescale 1ns / 1ps

package fpfa_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 64;
   localparam int DEFAULT_SIZE_BITS   = 16;

   localparam int CFG_COUNT_BITS = 7;
   localparam int POLICY_BITS    = 2;
   localparam int ENTRY_BITS     = 6;
   localparam int PORT_SIZE_BITS = 16;
   localparam int STATUS_BITS    = 2;
   localparam int IDX_CMP_BITS   = 11;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 7;

   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_REQUEST = 1'b1;

   localparam logic [STATUS_BITS-1:0] STATUS_LOADED  = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_GRANTED = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_NO_FIT  = 2'd2;

   localparam logic [POLICY_BITS-1:0] POLICY_FIRST = 2'd0;
   localparam logic [POLICY_BITS-1:0] POLICY_BEST  = 2'd1;
   localparam logic [POLICY_BITS-1:0] POLICY_WORST = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_BLOCKS_IN_USE = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIT_POLICY    = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH,
      ST_FINISH
   } fpfa_state_type;

   typedef struct packed {
      logic load;
      logic capture;
      logic read;
      logic finish;
   } fpfa_cmd_type;

endpackage

/* rtl/fpfa_ctrl.sv */
// Sequencer of the fixed partition fit allocator: accepts beats, steps the table scan.
// Depends on fpfa_pkg and fixed_partition_fit_allocator_defines.svh.
`timescale 1ns / 1ps
`include "fixed_partition_fit_allocator_defines.svh"

module fpfa_ctrl
   import fpfa_pkg::*;
#(
   parameter int AW = 6,
   parameter int CW = 7
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         req_cmd,
   input  logic [CW-1:0] scan_count,
   output logic         busy,
   output fpfa_cmd_type cmd,
   output logic [AW-1:0] rd_addr
);

   fpfa_state_type state_ff, state_in;
   logic [CW-1:0]  cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      rd_addr  = cnt_ff[AW-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_cmd == CMD_LOAD) begin
                  cmd.load = 1'b1;
               end else begin
                  cmd.capture = 1'b1;
                  cnt_in      = '0;
                  state_in    = (scan_count == '0) ? ST_FINISH : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.read = 1'b1;
            cnt_in   = cnt_ff + CW'(1);
            if (cnt_ff == (scan_count - CW'(1))) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   `FPFA_ASSERT_NEXT(a_req_enters_scan, clock, reset,
      (state_ff == ST_IDLE && start && req_cmd == CMD_REQUEST && scan_count != '0),
      (state_ff == ST_SCAN))
   `FPFA_ASSERT_NEXT(a_flush_then_finish, clock, reset, (state_ff == ST_FLUSH),
      (state_ff == ST_FINISH && cmd.finish))
   `FPFA_ASSERT_NOW(a_scan_in_range, clock, reset, (state_ff == ST_SCAN),
      (cnt_ff < scan_count))

endmodule

/* rtl/fpfa_dp.sv */
// Datapath of the fixed partition fit allocator: size table, used marks, fit compare,
// control registers and result registers. Depends on fpfa_pkg.
`timescale 1ns / 1ps

module fpfa_dp
   import fpfa_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
   parameter int SIZE_BITS   = DEFAULT_SIZE_BITS,
   parameter int AW          = 6,
   parameter int CW          = 7
) (
   input  logic                      clock,
   input  logic                      reset,
   input  fpfa_cmd_type              cmd,
   input  logic [AW-1:0]             rd_addr,
   input  logic [ENTRY_BITS-1:0]     req_entry_index,
   input  logic [PORT_SIZE_BITS-1:0] req_size_value,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wr_data,
   output logic [CW-1:0]             scan_count,
   output logic                      rsp_strobe,
   output logic [STATUS_BITS-1:0]    rsp_status,
   output logic [ENTRY_BITS-1:0]     rsp_granted_entry,
   output logic [PORT_SIZE_BITS-1:0] rsp_granted_size,
   output logic [PORT_SIZE_BITS-1:0] rsp_leftover
);

   logic [SIZE_BITS-1:0]      mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]    used_ff;
   logic [CFG_COUNT_BITS-1:0] blocks_ff;
   logic [POLICY_BITS-1:0]    policy_ff;

   logic [SIZE_BITS-1:0] req_size_ff;
   logic [SIZE_BITS-1:0] rd_data_ff;
   logic [AW-1:0]        rd_idx_ff;
   logic                 rd_used_ff;
   logic                 rd_vld_ff;

   logic                 found_ff;
   logic [AW-1:0]        best_idx_ff;
   logic [SIZE_BITS-1:0] best_size_ff;

   logic                      strobe_ff;
   logic [STATUS_BITS-1:0]    status_ff;
   logic [ENTRY_BITS-1:0]     entry_ff;
   logic [PORT_SIZE_BITS-1:0] gsize_ff;
   logic [PORT_SIZE_BITS-1:0] left_ff;

   logic          load_ok;
   logic [AW-1:0] load_addr;
   logic          fits;
   logic          take;

   assign load_ok   = ({(IDX_CMP_BITS-ENTRY_BITS)'(0), req_entry_index}
                       < IDX_CMP_BITS'(TABLE_DEPTH));
   assign load_addr = AW'(req_entry_index);

   assign scan_count = ((IDX_CMP_BITS'(blocks_ff) > IDX_CMP_BITS'(TABLE_DEPTH))
                        ? CW'(TABLE_DEPTH) : CW'(blocks_ff));

   assign fits = rd_vld_ff && !rd_used_ff && (rd_data_ff >= req_size_ff);
   assign take = fits && (!found_ff
                 || (policy_ff == POLICY_BEST  && rd_data_ff < best_size_ff)
                 || (policy_ff == POLICY_WORST && rd_data_ff > best_size_ff));

   always_ff @(posedge clock) begin
      if (cmd.load && load_ok) begin
         mem[load_addr] <= SIZE_BITS'(req_size_value);
      end
      if (cmd.read) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff   <= '0;
         blocks_ff <= '0;
         policy_ff <= POLICY_FIRST;
         rd_vld_ff <= 1'b0;
         found_ff  <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_BLOCKS_IN_USE: blocks_ff <= csr_wr_data[CFG_COUNT_BITS-1:0];
               CSR_FIT_POLICY:    policy_ff <= csr_wr_data[POLICY_BITS-1:0];
               default:           blocks_ff <= blocks_ff;
            endcase
         end
         rd_vld_ff <= cmd.read;
         strobe_ff <= cmd.load || cmd.finish;
         if (cmd.capture) begin
            found_ff <= 1'b0;
         end else if (take) begin
            found_ff <= 1'b1;
         end
         if (cmd.load && load_ok) begin
            used_ff[load_addr] <= 1'b0;
         end else if (cmd.finish && found_ff) begin
            used_ff[best_idx_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_size_ff <= SIZE_BITS'(req_size_value);
      end
      if (cmd.read) begin
         rd_idx_ff  <= rd_addr;
         rd_used_ff <= used_ff[rd_addr];
      end
      if (take) begin
         best_idx_ff  <= rd_idx_ff;
         best_size_ff <= rd_data_ff;
      end
      if (cmd.load) begin
         status_ff <= STATUS_LOADED;
         entry_ff  <= '0;
         gsize_ff  <= '0;
         left_ff   <= '0;
      end else if (cmd.finish) begin
         if (found_ff) begin
            status_ff <= STATUS_GRANTED;
            entry_ff  <= ENTRY_BITS'(best_idx_ff);
            gsize_ff  <= PORT_SIZE_BITS'(best_size_ff);
            left_ff   <= PORT_SIZE_BITS'(best_size_ff - req_size_ff);
         end else begin
            status_ff <= STATUS_NO_FIT;
            entry_ff  <= '0;
            gsize_ff  <= '0;
            left_ff   <= '0;
         end
      end
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_status        = status_ff;
   assign rsp_granted_entry = entry_ff;
   assign rsp_granted_size  = gsize_ff;
   assign rsp_leftover      = left_ff;

endmodule

/* rtl/fixed_partition_fit_allocator.sv */
// Load beat: result strobe in the cycle after acceptance; busy never rises; one load per cycle.
// Request beat: one table entry read per cycle from the single-port size table. The scan
// reads n = min(blocks_in_use, TABLE_DEPTH) entries, then passes the flush and finish states
// (straight to finish when n is zero); busy is high in every cycle before the strobe cycle.
// A new beat is taken in the strobe cycle. Reset clears used marks, control registers and
// sequencer; the size table is not cleared. The receiver cannot stall.
`timescale 1ns / 1ps

module fixed_partition_fit_allocator
   import fpfa_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
   parameter int SIZE_BITS   = DEFAULT_SIZE_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_cmd,
   input  logic [ENTRY_BITS-1:0]     req_entry_index,
   input  logic [PORT_SIZE_BITS-1:0] req_size_value,
   output logic                      rsp_strobe,
   output logic [STATUS_BITS-1:0]    rsp_status,
   output logic [ENTRY_BITS-1:0]     rsp_granted_entry,
   output logic [PORT_SIZE_BITS-1:0] rsp_granted_size,
   output logic [PORT_SIZE_BITS-1:0] rsp_leftover,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wr_data
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   fpfa_cmd_type  cmd;
   logic [AW-1:0] rd_addr;
   logic [CW-1:0] scan_count;

   fpfa_ctrl #(
      .AW(AW),
      .CW(CW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_cmd    (req_cmd),
      .scan_count (scan_count),
      .busy       (busy),
      .cmd        (cmd),
      .rd_addr    (rd_addr)
   );

   fpfa_dp #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .SIZE_BITS   (SIZE_BITS),
      .AW          (AW),
      .CW          (CW)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .rd_addr           (rd_addr),
      .req_entry_index   (req_entry_index),
      .req_size_value    (req_size_value),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data),
      .scan_count        (scan_count),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_granted_entry (rsp_granted_entry),
      .rsp_granted_size  (rsp_granted_size),
      .rsp_leftover      (rsp_leftover)
   );

endmodule

/* verif/testbench.sv */
// Self-checking testbench for fixed_partition_fit_allocator: load and request beats
// are predicted against a local copy of the size table, used marks and registers.
// Depends on fpfa_pkg and the allocator RTL.
`timescale 1ns / 1ps

module testbench;
   import fpfa_pkg::*;

   localparam int DEPTH = DEFAULT_TABLE_DEPTH;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = DEPTH + 8;
   localparam int PHASES = 10;
   localparam int BEATS_PER_PHASE = 95;
   localparam logic [POLICY_BITS-1:0] POLICY_UNUSED = 2'd3;

   typedef struct packed {
      logic                      cmd;
      logic [ENTRY_BITS-1:0]     entry_index;
      logic [PORT_SIZE_BITS-1:0] size_value;
   } alloc_beat_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0]    status;
      logic [ENTRY_BITS-1:0]     entry;
      logic [PORT_SIZE_BITS-1:0] gsize;
      logic [PORT_SIZE_BITS-1:0] leftover;
   } alloc_result_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic                      req_cmd = CMD_LOAD;
   logic [ENTRY_BITS-1:0]     req_entry_index = '0;
   logic [PORT_SIZE_BITS-1:0] req_size_value = '0;
   logic                      rsp_strobe;
   logic [STATUS_BITS-1:0]    rsp_status;
   logic [ENTRY_BITS-1:0]     rsp_granted_entry;
   logic [PORT_SIZE_BITS-1:0] rsp_granted_size;
   logic [PORT_SIZE_BITS-1:0] rsp_leftover;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_BLOCKS_IN_USE;
   logic [CSR_DATA_BITS-1:0]  csr_wr_data = '0;

   // local copy of the allocator state
   logic [PORT_SIZE_BITS-1:0] size_tbl [DEPTH];
   bit                        used_tbl [DEPTH];
   logic [CSR_DATA_BITS-1:0]  cfg_count = '0;
   logic [POLICY_BITS-1:0]    cfg_policy = POLICY_FIRST;

   alloc_beat_type   pending_beats[$];
   alloc_result_type pending_answers[$];
   alloc_beat_type   held_beat;
   bit               loaded_mask [DEPTH];
   int               burst_left = 0;
   int               gap_left = 0;
   int               fail_count = 0;
   int               cycle_count = 0;

   fixed_partition_fit_allocator i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_entry_index   (req_entry_index),
      .req_size_value    (req_size_value),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_granted_entry (rsp_granted_entry),
      .rsp_granted_size  (rsp_granted_size),
      .rsp_leftover      (rsp_leftover),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic alloc_result_type compute_allocation(input alloc_beat_type beat);
      alloc_result_type          r;
      int                        n;
      bit                        found;
      int                        pick;
      logic [PORT_SIZE_BITS-1:0] pick_size;
      r = '0;
      if (beat.cmd == CMD_LOAD) begin
         size_tbl[beat.entry_index] = beat.size_value;
         used_tbl[beat.entry_index] = 1'b0;
         r.status = STATUS_LOADED;
         return r;
      end
      n = (cfg_count > DEPTH) ? DEPTH : int'(cfg_count);
      found = 1'b0;
      pick = 0;
      pick_size = '0;
      for (int j = 0; j < n; j++) begin
         if (!used_tbl[j] && size_tbl[j] >= beat.size_value) begin
            if (!found) begin
               found = 1'b1;
               pick = j;
               pick_size = size_tbl[j];
               if (cfg_policy != POLICY_BEST && cfg_policy != POLICY_WORST)
                  break;
            end else if (cfg_policy == POLICY_BEST && size_tbl[j] < pick_size) begin
               pick = j;
               pick_size = size_tbl[j];
            end else if (cfg_policy == POLICY_WORST && size_tbl[j] > pick_size) begin
               pick = j;
               pick_size = size_tbl[j];
            end
         end
      end
      if (!found) begin
         r.status = STATUS_NO_FIT;
         return r;
      end
      used_tbl[pick] = 1'b1;
      r.status = STATUS_GRANTED;
      r.entry = ENTRY_BITS'(pick);
      r.gsize = pick_size;
      r.leftover = pick_size - beat.size_value;
      return r;
   endfunction

   // driver: bursts of beats with random gaps
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_cmd <= CMD_LOAD;
         req_entry_index <= '0;
         req_size_value <= '0;
         for (int j = 0; j < DEPTH; j++)
            used_tbl[j] = 1'b0;
      end else begin
         if (start && !busy)
            pending_answers.push_back(compute_allocation(held_beat));
         if (!start || !busy) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (pending_beats.size() > 0) begin
               held_beat = pending_beats.pop_front();
               start <= 1'b1;
               req_cmd <= held_beat.cmd;
               req_entry_index <= held_beat.entry_index;
               req_size_value <= held_beat.size_value;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
               end else begin
                  burst_left--;
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each result beat with the oldest expectation
   always @(posedge clock) begin
      alloc_result_type got;
      alloc_result_type want;
      if (!reset && rsp_strobe) begin
         got = {rsp_status, rsp_granted_entry, rsp_granted_size, rsp_leftover};
         if (pending_answers.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected result beat: status %0d entry %0d size %0d leftover %0d",
                        got.status, got.entry, got.gsize, got.leftover);
         end else begin
            want = pending_answers.pop_front();
            if (got.status !== want.status || got.entry !== want.entry ||
                got.gsize !== want.gsize || got.leftover !== want.leftover) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("mismatch (exp/act): status %0d/%0d entry %0d/%0d size %0d/%0d %s %0d/%0d",
                           want.status, got.status, want.entry, got.entry,
                           want.gsize, got.gsize, "leftover", want.leftover, got.leftover);
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   function automatic logic [PORT_SIZE_BITS-1:0] draw_size();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2, 3: return PORT_SIZE_BITS'($urandom_range(0, 65535));
         4, 5, 6: return PORT_SIZE_BITS'($urandom_range(0, 15) * 256);
         default: return PORT_SIZE_BITS'($urandom_range(0, 15) * 256 + $urandom_range(0, 255));
      endcase
   endfunction

   task automatic queue_load(input int idx, input logic [PORT_SIZE_BITS-1:0] sz);
      pending_beats.push_back('{CMD_LOAD, ENTRY_BITS'(idx), sz});
      loaded_mask[idx] = 1'b1;
   endtask

   task automatic queue_request(input logic [PORT_SIZE_BITS-1:0] sz);
      pending_beats.push_back('{CMD_REQUEST, ENTRY_BITS'($urandom_range(0, DEPTH - 1)), sz});
   endtask

   task automatic wait_drained();
      do
         @(negedge clock);
      while (pending_beats.size() != 0 || start || pending_answers.size() != 0);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (index == CSR_BLOCKS_IN_USE)
         cfg_count = data;
      else
         cfg_policy = data[POLICY_BITS-1:0];
   endtask

   // hold the sender until idle, then reprogram both registers
   task automatic set_config(input int count, input logic [POLICY_BITS-1:0] policy);
      wait_drained();
      write_csr(CSR_BLOCKS_IN_USE, CSR_DATA_BITS'(count));
      write_csr(CSR_FIT_POLICY, CSR_DATA_BITS'(policy));
      @(negedge clock);
   endtask

   initial begin
      int                     phase_count [PHASES] = '{64, 1, 127, 0, 65, 64, 8, 32, -1, 64};
      logic [POLICY_BITS-1:0] phase_policy [PHASES] = '{POLICY_FIRST, POLICY_BEST, POLICY_WORST,
         POLICY_UNUSED, POLICY_BEST, POLICY_WORST, POLICY_FIRST, POLICY_UNUSED, POLICY_BEST,
         POLICY_WORST};
      int cnt;
      int span;
      for (int j = 0; j < DEPTH; j++)
         loaded_mask[j] = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // extremes, and a request with no entries considered
      queue_load(0, '0);
      queue_load(DEPTH - 1, '1);
      queue_load(1, 16'd100);
      queue_load(2, 16'd40);
      queue_load(3, 16'd100);
      queue_request(16'd0);

      // first fit, zero request on a zero-size block, oversize request
      set_config(4, POLICY_FIRST);
      queue_request(16'd50);
      queue_request(16'd0);
      queue_request('1);

      // best fit with a tie between equal blocks
      set_config(4, POLICY_BEST);
      queue_load(1, 16'd100);
      queue_load(0, '0);
      queue_request(16'd30);
      queue_request(16'd60);

      // worst fit with a tie, then a request nothing fits
      set_config(4, POLICY_WORST);
      queue_load(1, 16'd100);
      queue_load(2, 16'd40);
      queue_load(3, 16'd100);
      queue_request(16'd10);
      queue_request(16'd200);

      for (int p = 0; p < PHASES; p++) begin
         cnt = phase_count[p];
         if (cnt < 0)
            cnt = $urandom_range(0, 127);
         set_config(cnt, phase_policy[p]);
         span = (cnt > DEPTH) ? DEPTH : cnt;
         // load every considered entry before any request reads it
         for (int j = 0; j < span; j++)
            if (!loaded_mask[j])
               queue_load(j, draw_size());
         for (int k = 0; k < BEATS_PER_PHASE; k++) begin
            if ($urandom_range(0, 99) < 40) begin
               if (span > 0 && $urandom_range(0, 3) != 0)
                  queue_load($urandom_range(0, span - 1), draw_size());
               else
                  queue_load($urandom_range(0, DEPTH - 1), draw_size());
            end else begin
               queue_request(draw_size());
            end
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_answers.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

/* fixed_partition_fit_allocator.f */
+incdir+rtl
rtl/fpfa_pkg.sv
rtl/fpfa_ctrl.sv
rtl/fpfa_dp.sv
rtl/fixed_partition_fit_allocator.sv
verif/testbench.sv
